@@ hw/rtl/mdsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mdsp_pkg
// Shared constants for the move-distance speed profiler: fixed-point format,
// field widths, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package mdsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIST_SHIFT = FRAC_BITS + 1;  // radius * (da + db) / 2

  localparam int ANG_W   = 32;
  localparam int TIME_W  = 32;
  localparam int SUM_W   = ANG_W + 2;       // da + db, each 33 bits signed
  localparam int TRAV_W  = 48;
  localparam int TGT_W   = 31;
  localparam int SPD_W   = 18;
  localparam int SLOW_W  = 24;
  localparam int RAD_W   = 16;
  localparam int TMO_W   = 24;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int STAT_W  = 2;
  localparam int MULB_W  = SLOW_W + 1;       // signed operand B of the multiplier
  localparam int PROD_W  = SUM_W + MULB_W;
  localparam int REM_W   = TGT_W + 18;       // target minus |travelled|, signed
  localparam int DCNT_W  = $clog2(SPD_W);

  // register indexes
  localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CRUISE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_FLOOR    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOWDOWN = 3'd3;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TIMEOUT  = 3'd5;

  // reset values
  localparam logic [TGT_W-1:0]  RST_TARGET   = 31'd59926;
  localparam logic [SPD_W-1:0]  RST_CRUISE   = 18'd16384;
  localparam logic [SPD_W-1:0]  RST_FLOOR    = 18'd3277;
  localparam logic [SLOW_W-1:0] RST_SLOWDOWN = 24'd13107;
  localparam logic [RAD_W-1:0]  RST_RADIUS   = 16'd2913;
  localparam logic [TMO_W-1:0]  RST_TIMEOUT  = 24'd500000;

  // item kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_MOVING  = 2'd0;
  localparam logic [STAT_W-1:0] ST_WAITING = 2'd1;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

endpackage

@@ hw/rtl/move_distance_speed_profiler_core.sv @@
// ----------------------------------------------------------------------------
// move_distance_speed_profiler_core
// Two-wheel fixed-distance speed profiler: tracks travelled distance from
// encoder samples and answers each control tick with a speed and a status.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid/in_ready   | action, now_time, wheel_angle_a/_b
//  out      | out_valid/out_ready | speed_command, status (one per tick)
//  cfg      | cfg_wr_en           | cfg_index, cfg_data
//
//  A sample passes through decode, multiply and write back before the core
//  is ready again; a first sample passes through decode only.
//  A tick passes through decode and output; in the slowdown zone also a
//  multiply, write back and an 18-step restoring divide (shared subtractor).
//  Synchronous reset loads config reset values and clears profiler state.
//  A result waiting on out_ready holds the sequencer in its output state.
// ----------------------------------------------------------------------------
module move_distance_speed_profiler_core
  import mdsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [TIME_W-1:0]        now_time,
  input  logic signed [ANG_W-1:0]  wheel_angle_a,
  input  logic signed [ANG_W-1:0]  wheel_angle_b,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SPD_W-1:0]         speed_command,
  output logic [STAT_W-1:0]        status,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_WB     = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // configuration registers
  logic [TGT_W-1:0]  target_distance;
  logic [SPD_W-1:0]  cruise_speed;
  logic [SPD_W-1:0]  floor_speed;
  logic [SLOW_W-1:0] slowdown_distance;
  logic [RAD_W-1:0]  wheel_radius;
  logic [TMO_W-1:0]  feedback_timeout;

  // profiler state
  logic                     started;
  logic                     finished;
  logic [TIME_W-1:0]        last_sample_time;
  logic signed [ANG_W-1:0]  start_angle_a;
  logic signed [ANG_W-1:0]  start_angle_b;
  logic signed [TRAV_W-1:0] travelled;

  // sequencer and datapath
  logic [2:0]               state;
  logic                     act_q;
  logic [TIME_W-1:0]        now_q;
  logic signed [ANG_W-1:0]  ang_a_q;
  logic signed [ANG_W-1:0]  ang_b_q;
  logic signed [SUM_W-1:0]  mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SLOW_W-1:0]        div_rem;
  logic [SPD_W-1:0]         div_q;
  logic [DCNT_W-1:0]        div_cnt;
  logic [SPD_W-1:0]         spd;
  logic [STAT_W-1:0]        stat;

  // combinational helpers
  logic signed [SUM_W-1:0]  ang_sum;
  logic [TRAV_W-1:0]        abs_trav;
  logic signed [REM_W-1:0]  rem_dist;
  logic [TIME_W-1:0]        age;
  logic                     timed_out;
  logic                     in_zone;
  logic [SLOW_W:0]          div_shift;
  logic [SLOW_W+1:0]        div_diff;
  logic                     div_ge;
  logic [SPD_W-1:0]         div_q_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ang_sum = ({{2{ang_a_q[ANG_W-1]}}, ang_a_q} - {{2{start_angle_a[ANG_W-1]}}, start_angle_a})
            + ({{2{ang_b_q[ANG_W-1]}}, ang_b_q} - {{2{start_angle_b[ANG_W-1]}}, start_angle_b});
    abs_trav  = travelled[TRAV_W-1] ? TRAV_W'(-travelled) : TRAV_W'(travelled);
    rem_dist  = $signed({{(REM_W-TGT_W){1'b0}}, target_distance})
              - $signed({{(REM_W-TRAV_W){1'b0}}, abs_trav});
    age       = now_q - last_sample_time;
    timed_out = age > {{(TIME_W-TMO_W){1'b0}}, feedback_timeout};
    in_zone   = (slowdown_distance != '0)
             && (rem_dist < $signed({{(REM_W-SLOW_W){1'b0}}, slowdown_distance}));
    // one restoring divide step: shared subtractor
    div_shift  = {div_rem, div_q[SPD_W-1]};
    div_diff   = {1'b0, div_shift} - {2'b00, slowdown_distance};
    div_ge     = !div_diff[SLOW_W+1];
    div_q_next = {div_q[SPD_W-2:0], div_ge};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance   <= RST_TARGET;
      cruise_speed      <= RST_CRUISE;
      floor_speed       <= RST_FLOOR;
      slowdown_distance <= RST_SLOWDOWN;
      wheel_radius      <= RST_RADIUS;
      feedback_timeout  <= RST_TIMEOUT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET:   target_distance   <= cfg_data[TGT_W-1:0];
        REG_CRUISE:   cruise_speed      <= cfg_data[SPD_W-1:0];
        REG_FLOOR:    floor_speed       <= cfg_data[SPD_W-1:0];
        REG_SLOWDOWN: slowdown_distance <= cfg_data[SLOW_W-1:0];
        REG_RADIUS:   wheel_radius      <= cfg_data[RAD_W-1:0];
        REG_TIMEOUT:  feedback_timeout  <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act_q   <= action;
      now_q   <= now_time;
      ang_a_q <= wheel_angle_a;
      ang_b_q <= wheel_angle_b;
    end
    if (state == S_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      started          <= 1'b0;
      finished         <= 1'b0;
      last_sample_time <= '0;
      start_angle_a    <= '0;
      start_angle_b    <= '0;
      travelled        <= '0;
      out_valid        <= 1'b0;
      div_cnt          <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (act_q == ACT_SAMPLE) begin
            last_sample_time <= now_q;
            if (!started) begin
              start_angle_a <= ang_a_q;
              start_angle_b <= ang_b_q;
              started       <= 1'b1;
              state         <= S_IDLE;
            end else begin
              mul_a <= ang_sum;
              mul_b <= {{(MULB_W-RAD_W){1'b0}}, wheel_radius};
              state <= S_MUL;
            end
          end else begin
            spd <= '0;
            if (finished) begin
              stat  <= ST_DONE;
              state <= S_OUT;
            end else if (!started) begin
              stat  <= ST_WAITING;
              state <= S_OUT;
            end else if (timed_out) begin
              stat  <= ST_TIMEOUT;
              state <= S_OUT;
            end else if (rem_dist <= 0) begin
              finished <= 1'b1;
              stat     <= ST_DONE;
              state    <= S_OUT;
            end else if (in_zone) begin
              stat  <= ST_MOVING;
              mul_a <= {{(SUM_W-SPD_W){1'b0}}, cruise_speed};
              mul_b <= {1'b0, rem_dist[SLOW_W-1:0]};
              state <= S_MUL;
            end else begin
              stat  <= ST_MOVING;
              spd   <= cruise_speed;
              state <= S_OUT;
            end
          end
        end
        S_MUL: begin
          state <= S_WB;
          // quotient < 2^SPD_W since remaining < slowdown, so the top part
          // of the dividend is already below the divisor
          div_cnt <= '0;
        end
        S_WB: begin
          if (act_q == ACT_SAMPLE) begin
            // arithmetic shift floors toward minus infinity
            travelled <= TRAV_W'(prod >>> DIST_SHIFT);
            state     <= S_IDLE;
          end else begin
            div_rem <= prod[SLOW_W+SPD_W-1:SPD_W];
            div_q   <= prod[SPD_W-1:0];
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? div_diff[SLOW_W-1:0] : div_shift[SLOW_W-1:0];
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(SPD_W - 1)) begin
            spd   <= (div_q_next > floor_speed) ? div_q_next : floor_speed;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            speed_command <= spd;
            status        <= stat;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stopped_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_MOVING |-> speed_command == '0)
    else $error("non-zero speed with a stopped status");

  a_done_latched: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("done flag cleared");

  a_started_latched: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("start flag cleared");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt < DCNT_W'(SPD_W))
    else $error("divider ran past its step count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> state != S_IDLE || $stable(status))
    else $error("pending result overwritten");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the move-distance speed profiler core. Encoder
// samples and control ticks go in with random gaps and output stalls. A
// model of distance, ramp and status answers every tick, and each speed
// command leaving the core is checked against the oldest one due.
// ----------------------------------------------------------------------------
module tb_top
  import mdsp_pkg::*;
();

  localparam int     IDLE_LIMIT   = 4000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     HOLD_CYCLES  = 300;
  localparam longint ANG_SPAN     = 64'h0000_0000_FFFF_FFFF;
  // first sample sits at the angle extremes, so later angles span the full range
  localparam logic signed [ANG_W-1:0] ORIGIN_A = 32'sh8000_0000;
  localparam logic signed [ANG_W-1:0] ORIGIN_B = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic              act;
    logic [TIME_W-1:0] stamp;
    logic [ANG_W-1:0]  ang_a;
    logic [ANG_W-1:0]  ang_b;
  } motion_item_t;

  typedef struct packed {
    logic [SPD_W-1:0]  speed;
    logic [STAT_W-1:0] stat;
  } speed_cmd_t;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic                    action        = ACT_SAMPLE;
  logic [TIME_W-1:0]       now_time      = '0;
  logic signed [ANG_W-1:0] wheel_angle_a = '0;
  logic signed [ANG_W-1:0] wheel_angle_b = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic [SPD_W-1:0]        speed_command;
  logic [STAT_W-1:0]       status;
  logic                    cfg_wr_en     = 1'b0;
  logic [IDX_W-1:0]        cfg_index     = REG_TARGET;
  logic [CFG_W-1:0]        cfg_data      = '0;

  // profile settings as the core should hold them
  logic [TGT_W-1:0]  tgt_dist    = RST_TARGET;
  logic [SPD_W-1:0]  cruise_spd  = RST_CRUISE;
  logic [SPD_W-1:0]  floor_spd   = RST_FLOOR;
  logic [SLOW_W-1:0] slow_len    = RST_SLOWDOWN;
  logic [RAD_W-1:0]  radius      = RST_RADIUS;
  logic [TMO_W-1:0]  stale_limit = RST_TIMEOUT;

  // odometry state
  bit                has_origin = 1'b0;
  bit                arrived    = 1'b0;
  logic [TIME_W-1:0] last_stamp = '0;
  logic [ANG_W-1:0]  origin_a   = '0;
  logic [ANG_W-1:0]  origin_b   = '0;
  longint            travelled  = 0;

  motion_item_t      items_to_send[$];
  speed_cmd_t        cmds_due[$];
  logic [TIME_W-1:0] gen_now        = '0;
  int                queued_count   = 0;
  int                accepted_count = 0;
  int                mismatches     = 0;
  bit                steady         = 1'b0;

  move_distance_speed_profiler_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .now_time      (now_time),
    .wheel_angle_a (wheel_angle_a),
    .wheel_angle_b (wheel_angle_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .speed_command (speed_command),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Distance update on a sample, speed command on a tick.
  task automatic profile_step(input motion_item_t it);
    longint            sum;
    longint            mag;
    longint            prod;
    longint            rem;
    longint            ramp;
    logic [TIME_W-1:0] age;
    speed_cmd_t        cmd;
    if (it.act == ACT_SAMPLE) begin
      last_stamp = it.stamp;
      if (!has_origin) begin
        origin_a   = it.ang_a;
        origin_b   = it.ang_b;
        has_origin = 1'b1;
      end else begin
        sum = (longint'($signed(it.ang_a)) - longint'($signed(origin_a)))
            + (longint'($signed(it.ang_b)) - longint'($signed(origin_b)));
        mag  = (sum < 0) ? -sum : sum;
        prod = mag * longint'(radius);
        // negative travel rounds towards minus infinity
        if (sum < 0) travelled = -((prod + (64'd1 << DIST_SHIFT) - 1) >> DIST_SHIFT);
        else         travelled = prod >> DIST_SHIFT;
      end
    end else begin
      cmd.speed = '0;
      age       = it.stamp - last_stamp;
      if (arrived) begin
        cmd.stat = ST_DONE;
      end else if (!has_origin) begin
        cmd.stat = ST_WAITING;
      end else if (age > TIME_W'(stale_limit)) begin
        cmd.stat = ST_TIMEOUT;
      end else begin
        rem = longint'(tgt_dist) - ((travelled < 0) ? -travelled : travelled);
        if (rem <= 0) begin
          arrived  = 1'b1;
          cmd.stat = ST_DONE;
        end else begin
          cmd.stat  = ST_MOVING;
          cmd.speed = cruise_spd;
          if (slow_len != 0 && rem < longint'(slow_len)) begin
            ramp      = (longint'(cruise_spd) * rem) / longint'(slow_len);
            cmd.speed = (ramp > longint'(floor_spd)) ? SPD_W'(ramp) : floor_spd;
          end
        end
      end
      cmds_due.push_back(cmd);
    end
  endtask

  task automatic push_item(input logic act, input logic [ANG_W-1:0] a,
                           input logic [ANG_W-1:0] b);
    motion_item_t it;
    it.act   = act;
    it.stamp = gen_now;
    it.ang_a = a;
    it.ang_b = b;
    items_to_send.push_back(it);
    queued_count++;
  endtask

  task automatic push_tick();
    push_item(ACT_TICK, $urandom, $urandom);
  endtask

  // Sample whose summed angle change from the origin is s, split at random.
  task automatic send_sum(input longint s);
    longint lo;
    longint hi;
    longint da;
    lo = (s > 0) ? s : 0;
    hi = (s > 0) ? ANG_SPAN : s + ANG_SPAN;
    da = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
    push_item(ACT_SAMPLE, ANG_W'(longint'(ORIGIN_A) + da),
              ANG_W'(longint'(ORIGIN_B) + s - da));
  endtask

  // Sample aimed at a travelled distance of about d (never more in magnitude).
  task automatic send_dist(input longint d);
    longint mag;
    longint s;
    mag = (d < 0) ? -d : d;
    if (radius == 0) s = mag;
    else             s = (mag << DIST_SHIFT) / longint'(radius);
    if (s > ANG_SPAN) s = ANG_SPAN;
    send_sum((d < 0) ? -s : s);
  endtask

  // Distance short of the target, often inside the slowdown zone.
  function automatic longint aim_distance();
    longint lim;
    longint d;
    lim = tgt_dist;
    if (slow_len != 0 && slow_len < tgt_dist && $urandom_range(0, 9) < 6) lim = slow_len;
    if (lim == 0) return 0;
    d = longint'(tgt_dist) - (1 + longint'($urandom) % lim);
    return ($urandom_range(0, 3) == 0) ? -d : d;
  endfunction

  task automatic random_step();
    int pick;
    pick    = $urandom_range(0, 99);
    gen_now = gen_now + TIME_W'($urandom_range(0, stale_limit / 3));
    if (pick < 35) begin
      send_dist(aim_distance());
    end else if (pick < 75) begin
      push_tick();
    end else if (pick < 85) begin
      // junk angles, then a clean sample before any tick can see them
      gen_now = $urandom;
      push_item(ACT_SAMPLE, $urandom, $urandom);
      send_dist(aim_distance());
    end else if (pick < 95) begin
      gen_now = gen_now + stale_limit + 1
              + $urandom_range(0, 32'hFFFF_FFFF - stale_limit - 1);
      push_tick();
    end else begin
      send_dist(aim_distance());
      push_tick();
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TARGET:   tgt_dist    = val[TGT_W-1:0];
      REG_CRUISE:   cruise_spd  = val[SPD_W-1:0];
      REG_FLOOR:    floor_spd   = val[SPD_W-1:0];
      REG_SLOWDOWN: slow_len    = val[SLOW_W-1:0];
      REG_RADIUS:   radius      = val[RAD_W-1:0];
      REG_TIMEOUT:  stale_limit = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_profile(input longint t, input longint c, input longint f,
                              input longint s, input longint r, input longint o);
    write_reg(REG_TARGET,   CFG_W'(t));
    write_reg(REG_CRUISE,   CFG_W'(c));
    write_reg(REG_FLOOR,    CFG_W'(f));
    write_reg(REG_SLOWDOWN, CFG_W'(s));
    write_reg(REG_RADIUS,   CFG_W'(r));
    write_reg(REG_TIMEOUT,  CFG_W'(o));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait for every item to go in and every command to come out, then let a
  // trailing sample finish inside the core.
  task automatic settle();
    while (accepted_count != queued_count || cmds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : item_driver
    motion_item_t on_bus;
    int           gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_count++;
        profile_step(on_bus);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          on_bus = items_to_send.pop_front();
          in_valid      <= 1'b1;
          action        <= on_bus.act;
          now_time      <= on_bus.stamp;
          wheel_angle_a <= on_bus.ang_a;
          wheel_angle_b <= on_bus.ang_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : cmd_monitor
    speed_cmd_t want;
    int         results_seen;
    int         hold_left;
    int         stall_left;
    if (rst) begin
      out_ready <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
      stall_left   = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        // long hold-off so the core backs up onto its input
        if (results_seen == 60 || results_seen == 400) hold_left = HOLD_CYCLES;
        if (cmds_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command: speed %0d status %0d", speed_command, status);
        end else begin
          want = cmds_due.pop_front();
          if (speed_command !== want.speed || status !== want.stat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: speed exp %0d got %0d, status exp %0d got %0d",
                       want.speed, speed_command, want.stat, status);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    longint t_cfg;
    longint c_cfg;
    longint f_cfg;
    longint s_cfg;
    longint r_cfg;
    longint o_cfg;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ticks before any sample, at both ends of the clock range
    gen_now = '0;
    push_tick();
    gen_now = 32'hFFFF_FFFF;
    push_tick();
    gen_now = 32'd1000;
    push_item(ACT_SAMPLE, ORIGIN_A, ORIGIN_B);
    push_tick();
    // sample age exactly at the limit, then one past it
    gen_now = gen_now + RST_TIMEOUT;
    push_tick();
    gen_now = gen_now + 1;
    push_tick();
    send_dist(RST_TARGET - 6000);
    push_tick();
    send_dist(-(longint'(RST_TARGET) - 10));
    push_tick();

    settle();
    load_profile(32'h7FFF_FFFF, 18'h3FFFF, 0, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
    // largest forward and backward travel, time wrapping between sample and tick
    gen_now = 32'hFFFF_FFF0;
    push_item(ACT_SAMPLE, ORIGIN_B, ORIGIN_B);
    gen_now = 32'h0000_0010;
    push_tick();
    push_item(ACT_SAMPLE, ORIGIN_A, ORIGIN_A);
    push_tick();
    push_item(ACT_SAMPLE, ORIGIN_B, ORIGIN_A);
    push_tick();

    settle();
    // no ramp, no radius, zero timeout
    load_profile(100000, 1000, 18'h3FFFF, 0, 0, 0);
    send_dist(50000);
    push_tick();
    gen_now = gen_now + 1;
    push_tick();

    settle();
    // floor above cruise inside the zone
    load_profile(100000, 1000, 18'h3FFFF, 24'hFFFFFF, RST_RADIUS, 1000);
    send_dist(50000);
    push_tick();

    for (int k = 0; k < 12; k++) begin
      settle();
      if (k == 11) steady = 1'b1;
      t_cfg = (k % 3 == 0) ? $urandom_range(1, 200000) : $urandom_range(1, 32'h7FFF_FFFF);
      c_cfg = (k % 4 == 3) ? ((k % 8 == 3) ? 0 : 18'h3FFFF) : $urandom_range(0, 18'h3FFFF);
      f_cfg = $urandom_range(0, 18'h3FFFF) >> $urandom_range(0, 17);
      s_cfg = (k % 5 == 4) ? 0
            : $urandom_range(0, (t_cfg > 24'hFFFFFF) ? 24'hFFFFFF : t_cfg);
      r_cfg = (k % 6 == 5) ? 0 : $urandom_range(1, 16'hFFFF);
      o_cfg = (k % 3 == 2) ? $urandom_range(0, 50) : $urandom_range(0, 24'hFFFFFF);
      load_profile(t_cfg, c_cfg, f_cfg, s_cfg, r_cfg, o_cfg);
      send_dist(aim_distance());
      repeat (80) random_step();
    end

    settle();
    c_cfg = $urandom_range(0, 18'h3FFFF);
    f_cfg = $urandom_range(0, 18'h3FFFF);
    load_profile(1, c_cfg, f_cfg, 24'hFFFFFF, 32768, RST_TIMEOUT);
    // zero net travel: one unit short of the target
    push_item(ACT_SAMPLE, ORIGIN_B, ORIGIN_A);
    push_tick();
    settle();
    load_profile(0, c_cfg, f_cfg, 24'hFFFFFF, 32768, RST_TIMEOUT);
    // remaining exactly zero latches done; nothing afterwards undoes it
    push_tick();
    send_dist(5000);
    push_tick();
    gen_now = gen_now + 32'h8000_0000;
    push_tick();
    repeat (10) random_step();

    settle();
    mismatches += cmds_due.size();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
